@@ rtl/tsi_pkg.sv @@
// Shared types, widths and codes of the timestamped sample interpolator.
`timescale 1ns / 1ps

package tsi_pkg;

   // Default number of snapshots kept in the history.
   localparam int HISTORY_DEPTH_DEF = 10;

   // Field widths.
   localparam int TIME_W = 32;
   localparam int POS_W = 24;
   localparam int FRAC_W = 16;
   localparam int SAMPLE_W = TIME_W + 4 * POS_W;
   localparam int RSP_DATA_W = 4 * POS_W;

   // Request kinds carried on req_tuser.
   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Query outcomes carried on rsp_tuser.
   typedef enum logic [1:0] {
      OUTCOME_EMPTY    = 2'd0,
      OUTCOME_SINGLE   = 2'd1,
      OUTCOME_FALLBACK = 2'd2,
      OUTCOME_INTERP   = 2'd3
   } outcome_type;

   // A position or velocity pair, x in the low bits.
   typedef struct packed {
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } point_type;

   // One stored snapshot, laid out as the request word, time in the low bits.
   typedef struct packed {
      point_type          vel;
      point_type          pos;
      logic [TIME_W-1:0]  time_us;
   } sample_type;

   // Handshake between the sequencer and the fraction divider.
   typedef struct packed {
      logic               start;
      logic [TIME_W-1:0]  progress;
      logic [TIME_W-1:0]  span;
   } div_req_type;

endpackage

@@ rtl/timestamped_sample_interpolator.sv @@
// Top level: snapshot history in RAM, scan sequencer, divider and blend units.
//
//   port group | direction | tdata (low bit up)                         | tuser
//   req_*      | in        | time_us, snap_pos_x, snap_pos_y,           | req_type
//              |           | snap_vel_x, snap_vel_y (128 bits)          |
//   rsp_*      | out       | shown_x, shown_y, held_vel_x, held_vel_y   | outcome
//
// An add is written to the history RAM on acceptance.
// A query on an empty history goes straight to the hand-off; otherwise it reads the
// history one RAM entry a cycle in the scan, and an interpolating query then passes
// through the serial fraction divider and the blend unit before the result is loaded.
// Reset is synchronous and clears the counters and the held velocity; the RAM
// needs no clearing since only written entries are ever used.
// A query result waits in the output register while a stalled rsp side holds it.
`timescale 1ns / 1ps

module timestamped_sample_interpolator #(
   parameter int HISTORY_DEPTH = tsi_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // time_us, snap_pos_x, snap_pos_y, snap_vel_x, snap_vel_y
   input  logic [tsi_pkg::SAMPLE_W-1:0]      req_tdata,
   // req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // shown_x, shown_y, held_vel_x, held_vel_y
   output logic [tsi_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // outcome
   output logic [1:0]                        rsp_tuser
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = $clog2(2 * HISTORY_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_NEWEST = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_BLEND  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] slot);
      logic [AW-1:0] nxt;
      nxt = (slot == AW'(HISTORY_DEPTH - 1)) ? '0 : slot + AW'(1);
      return nxt;
   endfunction

   state_type                    state_ff, state_in;
   logic [CW-1:0]                entry_count_ff, entry_count_in;
   logic [AW-1:0]                oldest_ff, oldest_in;
   tsi_pkg::point_type           obj_vel_ff, obj_vel_in;
   logic [tsi_pkg::TIME_W-1:0]   tq_ff, tq_in;
   logic [AW-1:0]                issue_slot_ff, issue_slot_in;
   logic [CW-1:0]                eval_idx_ff, eval_idx_in;
   logic                         have_from_ff, have_from_in;
   logic [tsi_pkg::TIME_W-1:0]   from_t_ff, from_t_in;
   tsi_pkg::point_type           from_pos_ff, from_pos_in;
   tsi_pkg::point_type           to_pos_ff, to_pos_in;
   tsi_pkg::point_type           to_vel_ff, to_vel_in;
   tsi_pkg::outcome_type         pend_outcome_ff, pend_outcome_in;
   tsi_pkg::point_type           pend_pos_ff, pend_pos_in;
   tsi_pkg::point_type           pend_vel_ff, pend_vel_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tsi_pkg::outcome_type         rsp_outcome_ff, rsp_outcome_in;
   tsi_pkg::point_type           rsp_pos_ff, rsp_pos_in;
   tsi_pkg::point_type           rsp_vel_ff, rsp_vel_in;

   logic                         accept;
   logic                         is_query;
   logic                         full;
   tsi_pkg::sample_type          req_sample;
   tsi_pkg::sample_type          rd_sample;
   logic [SW-1:0]                append_sum, newest_sum;
   logic [AW-1:0]                append_slot, newest_slot;
   logic [AW-1:0]                next_issue;
   logic                         hit_after;
   logic                         scan_last;
   logic                         single;

   logic                         ram_we;
   logic [AW-1:0]                ram_wa;
   logic [AW-1:0]                ram_ra;
   logic [tsi_pkg::SAMPLE_W-1:0] ram_rd_data;

   tsi_pkg::div_req_type         div_req;
   logic                         div_done;
   logic [tsi_pkg::FRAC_W-1:0]   factor;
   logic                         blend_done;
   tsi_pkg::point_type           blend_pos;

   // Request decode and slot arithmetic around the circular history.
   assign req_tready = state_ff == ST_IDLE;
   assign accept = req_tvalid && req_tready;
   assign is_query = req_tuser == tsi_pkg::REQ_QUERY;
   assign req_sample = tsi_pkg::sample_type'(req_tdata);
   assign rd_sample = tsi_pkg::sample_type'(ram_rd_data);
   assign full = entry_count_ff == CW'(HISTORY_DEPTH);
   assign single = entry_count_ff == CW'(1);

   assign append_sum = SW'(oldest_ff) + SW'(entry_count_ff);
   assign newest_sum = SW'(oldest_ff) + SW'(entry_count_ff) - SW'(1);
   assign append_slot = (append_sum >= SW'(HISTORY_DEPTH)) ?
                        AW'(append_sum - SW'(HISTORY_DEPTH)) : AW'(append_sum);
   assign newest_slot = (newest_sum >= SW'(HISTORY_DEPTH)) ?
                        AW'(newest_sum - SW'(HISTORY_DEPTH)) : AW'(newest_sum);
   assign next_issue = wrap_inc(issue_slot_ff);

   assign hit_after = rd_sample.time_us > tq_ff;
   assign scan_last = eval_idx_ff == (entry_count_ff - CW'(1));

   // History RAM ports: adds write on acceptance, the scan reads one entry a cycle.
   assign ram_we = accept && !is_query;
   assign ram_wa = full ? oldest_ff : append_slot;

   always_comb begin
      ram_ra = issue_slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_ra = oldest_ff;
         end
         ST_SCAN: begin
            // The oldest entry already lies after the query time: fetch the newest.
            if (!single && hit_after && !have_from_ff) begin
               ram_ra = newest_slot;
            end else begin
               ram_ra = next_issue;
            end
         end
         ST_NEWEST, ST_DIVIDE, ST_BLEND, ST_EMIT: begin
            ram_ra = issue_slot_ff;
         end
         default: begin
            ram_ra = issue_slot_ff;
         end
      endcase
   end

   tsi_ram #(
      .WIDTH (tsi_pkg::SAMPLE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (req_tdata),
      .rd_en   (1'b1),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_data)
   );

   // The factor divider starts when the scan finds the bracketing pair.
   always_comb begin
      div_req.start = (state_ff == ST_SCAN) && !single && hit_after && have_from_ff;
      div_req.progress = tq_ff - from_t_ff;
      div_req.span = rd_sample.time_us - from_t_ff;
   end

   tsi_frac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .done   (div_done),
      .factor (factor)
   );

   tsi_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_DIVIDE) && div_done),
      .factor   (factor),
      .from_pos (from_pos_ff),
      .to_pos   (to_pos_ff),
      .done     (blend_done),
      .shown    (blend_pos)
   );

   // Sequencer: history update, scan, arithmetic and result hand-off.
   always_comb begin
      state_in = state_ff;
      entry_count_in = entry_count_ff;
      oldest_in = oldest_ff;
      obj_vel_in = obj_vel_ff;
      tq_in = tq_ff;
      issue_slot_in = issue_slot_ff;
      eval_idx_in = eval_idx_ff;
      have_from_in = have_from_ff;
      from_t_in = from_t_ff;
      from_pos_in = from_pos_ff;
      to_pos_in = to_pos_ff;
      to_vel_in = to_vel_ff;
      pend_outcome_in = pend_outcome_ff;
      pend_pos_in = pend_pos_ff;
      pend_vel_in = pend_vel_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_query) begin
               if (full) begin
                  oldest_in = wrap_inc(oldest_ff);
               end else begin
                  entry_count_in = entry_count_ff + CW'(1);
               end
            end else if (accept) begin
               tq_in = req_sample.time_us;
               issue_slot_in = oldest_ff;
               eval_idx_in = '0;
               have_from_in = 1'b0;
               if (entry_count_ff == '0) begin
                  pend_outcome_in = tsi_pkg::OUTCOME_EMPTY;
                  pend_pos_in = '0;
                  pend_vel_in = obj_vel_ff;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue_slot_in = next_issue;
            if (single) begin
               pend_outcome_in = tsi_pkg::OUTCOME_SINGLE;
               pend_pos_in = rd_sample.pos;
               pend_vel_in = obj_vel_ff;
               state_in = ST_EMIT;
            end else if (!hit_after) begin
               from_t_in = rd_sample.time_us;
               from_pos_in = rd_sample.pos;
               have_from_in = 1'b1;
               eval_idx_in = eval_idx_ff + CW'(1);
               // Every entry is at or before the query time: the last one is the newest.
               if (scan_last) begin
                  pend_outcome_in = tsi_pkg::OUTCOME_FALLBACK;
                  pend_pos_in = rd_sample.pos;
                  pend_vel_in = rd_sample.vel;
                  state_in = ST_EMIT;
               end
            end else if (have_from_ff) begin
               to_pos_in = rd_sample.pos;
               to_vel_in = rd_sample.vel;
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_NEWEST;
            end
         end
         ST_NEWEST: begin
            pend_outcome_in = tsi_pkg::OUTCOME_FALLBACK;
            pend_pos_in = rd_sample.pos;
            pend_vel_in = rd_sample.vel;
            state_in = ST_EMIT;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_done) begin
               pend_outcome_in = tsi_pkg::OUTCOME_INTERP;
               pend_pos_in = blend_pos;
               pend_vel_in = to_vel_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load the output register once the previous word has been taken.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_outcome_in = pend_outcome_ff;
               rsp_pos_in = pend_pos_ff;
               rsp_vel_in = pend_vel_ff;
               obj_vel_in = pend_vel_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_count_ff <= '0;
         oldest_ff <= '0;
         obj_vel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         entry_count_ff <= entry_count_in;
         oldest_ff <= oldest_in;
         obj_vel_ff <= obj_vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tq_ff <= tq_in;
      issue_slot_ff <= issue_slot_in;
      eval_idx_ff <= eval_idx_in;
      have_from_ff <= have_from_in;
      from_t_ff <= from_t_in;
      from_pos_ff <= from_pos_in;
      to_pos_ff <= to_pos_in;
      to_vel_ff <= to_vel_in;
      pend_outcome_ff <= pend_outcome_in;
      pend_pos_ff <= pend_pos_in;
      pend_vel_ff <= pend_vel_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_vel_ff, rsp_pos_ff};
   assign rsp_tuser = rsp_outcome_ff;

   // The history RAM is only written between queries.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("history written during a query");

   // The entry count never passes the history depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CW'(HISTORY_DEPTH))
      else $error("entry count beyond history depth");

   // The oldest pointer only moves once the history has filled.
   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> full)
      else $error("oldest pointer moved before the history filled");

   // A new result word only comes from the hand-off state.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside the hand-off state");

   // The divider finishes only while the sequencer waits for it.
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside its wait state");

endmodule

@@ rtl/tsi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tsi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tsi_frac_div.sv @@
// Restoring divider that produces the Q0.16 interpolation factor one bit a cycle.
`timescale 1ns / 1ps

module tsi_frac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  tsi_pkg::div_req_type        req,
   output logic                        done,
   output logic [tsi_pkg::FRAC_W-1:0]  factor
);

   localparam int STEP_W = $clog2(tsi_pkg::FRAC_W + 1);

   logic [tsi_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [tsi_pkg::TIME_W-1:0] span_ff, span_in;
   logic [tsi_pkg::FRAC_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [tsi_pkg::TIME_W:0]   shifted;
   logic                       fits;

   // The remainder stays below the span, so its double fits one extra bit.
   assign shifted = {rem_ff, 1'b0};
   assign fits = shifted >= {1'b0, span_ff};

   // One quotient bit per cycle; progress is below span so the factor stays under one.
   always_comb begin
      rem_in = rem_ff;
      span_in = span_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = req.progress;
         span_in = req.span;
         quo_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? tsi_pkg::TIME_W'(shifted - {1'b0, span_ff})
                       : shifted[tsi_pkg::TIME_W-1:0];
         quo_in = {quo_ff[tsi_pkg::FRAC_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(tsi_pkg::FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      span_ff <= span_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign factor = quo_ff;

endmodule

@@ rtl/tsi_blend.sv @@
// Two-stage linear blend of a position pair by the Q0.16 factor, rounded toward minus infinity.
`timescale 1ns / 1ps

module tsi_blend (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tsi_pkg::FRAC_W-1:0]  factor,
   input  tsi_pkg::point_type          from_pos,
   input  tsi_pkg::point_type          to_pos,
   output logic                        done,
   output tsi_pkg::point_type          shown
);

   localparam int DIFF_W = tsi_pkg::POS_W + 1;
   localparam int PROD_W = DIFF_W + tsi_pkg::FRAC_W + 1;

   logic signed [DIFF_W-1:0]           diff_x, diff_y;
   logic signed [tsi_pkg::FRAC_W:0]    factor_s;
   logic signed [PROD_W-1:0]           prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]           prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0]           sum_x, sum_y;
   logic                               stage1_ff, stage2_ff;
   tsi_pkg::point_type                 shown_ff, shown_in;

   // Stage one: difference times factor.
   assign diff_x = DIFF_W'(to_pos.x) - DIFF_W'(from_pos.x);
   assign diff_y = DIFF_W'(to_pos.y) - DIFF_W'(from_pos.y);
   assign factor_s = $signed({1'b0, factor});
   assign prod_x_in = PROD_W'(diff_x) * PROD_W'(factor_s);
   assign prod_y_in = PROD_W'(diff_y) * PROD_W'(factor_s);

   // Stage two: arithmetic shift floors the scaled difference; the sum stays in range.
   assign sum_x = PROD_W'(from_pos.x) + (prod_x_ff >>> tsi_pkg::FRAC_W);
   assign sum_y = PROD_W'(from_pos.y) + (prod_y_ff >>> tsi_pkg::FRAC_W);
   assign shown_in.x = sum_x[tsi_pkg::POS_W-1:0];
   assign shown_in.y = sum_y[tsi_pkg::POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
      end else begin
         stage1_ff <= start;
         stage2_ff <= stage1_ff;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      shown_ff <= shown_in;
   end

   assign done = stage2_ff;
   assign shown = shown_ff;

endmodule

@@ sim/tsi_checker.sv @@
// Checker for the timestamped sample interpolator: tracks the history, predicts and compares.
`timescale 1ns / 1ps

module tsi_checker #(
   parameter int HISTORY_DEPTH = tsi_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // time_us, snap_pos_x, snap_pos_y, snap_vel_x, snap_vel_y
   input  logic [tsi_pkg::SAMPLE_W-1:0]      req_tdata,
   // req_type
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // shown_x, shown_y, held_vel_x, held_vel_y
   input  logic [tsi_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // outcome
   input  logic [1:0]                        rsp_tuser,
   output int                                mismatch_count,
   output int                                pending_count
);
   import tsi_pkg::*;

   // One predicted query answer.
   typedef struct {
      outcome_type             outcome;
      logic signed [POS_W-1:0] shown_x;
      logic signed [POS_W-1:0] shown_y;
      logic signed [POS_W-1:0] vel_x;
      logic signed [POS_W-1:0] vel_y;
   } answer_type;

   // Private copy of the block state.
   sample_type  snap_history [HISTORY_DEPTH];
   int unsigned oldest_idx;
   int unsigned snap_fill;
   point_type   held_vel;

   answer_type  query_answers [$];
   int          errors = 0;

   // Moves a coordinate from a toward b by frac / 65536, rounding toward minus infinity.
   function automatic logic signed [POS_W-1:0] blend_coord(input logic signed [POS_W-1:0] a,
                                                           input logic signed [POS_W-1:0] b,
                                                           input logic [63:0] frac);
      longint diff;
      longint prod;
      diff = longint'(b) - longint'(a);
      prod = diff * longint'(frac);
      return POS_W'(longint'(a) + (prod >>> FRAC_W));
   endfunction

   // Applies one accepted request word to the history and queues the answer of a query.
   task automatic track_request(input logic kind, input sample_type word);
      int unsigned slot;
      int unsigned lo_slot;
      int unsigned hi_slot;
      int unsigned newest;
      bit          have_lo;
      bit          have_hi;
      logic [63:0] span;
      logic [63:0] prog;
      logic [63:0] frac;
      answer_type  ans;
      if (kind == REQ_ADD) begin
         if (snap_fill < HISTORY_DEPTH) begin
            slot = (oldest_idx + snap_fill) % HISTORY_DEPTH;
            snap_fill++;
         end else begin
            slot = oldest_idx;
            oldest_idx = (oldest_idx + 1) % HISTORY_DEPTH;
         end
         snap_history[slot] = word;
         return;
      end
      ans.shown_x = '0;
      ans.shown_y = '0;
      lo_slot = 0;
      hi_slot = 0;
      have_lo = 0;
      have_hi = 0;
      if (snap_fill == 0) begin
         ans.outcome = OUTCOME_EMPTY;
      end else if (snap_fill == 1) begin
         ans.outcome = OUTCOME_SINGLE;
         ans.shown_x = snap_history[oldest_idx].pos.x;
         ans.shown_y = snap_history[oldest_idx].pos.y;
      end else begin
         // Scan oldest to newest; stop at the first entry later than the query time.
         for (int unsigned i = 0; i < snap_fill; i++) begin
            slot = (oldest_idx + i) % HISTORY_DEPTH;
            if (snap_history[slot].time_us <= word.time_us) begin
               lo_slot = slot;
               have_lo = 1;
            end else begin
               hi_slot = slot;
               have_hi = 1;
               break;
            end
         end
         if (!(have_lo && have_hi)) begin
            newest = (oldest_idx + snap_fill - 1) % HISTORY_DEPTH;
            ans.outcome = OUTCOME_FALLBACK;
            ans.shown_x = snap_history[newest].pos.x;
            ans.shown_y = snap_history[newest].pos.y;
            held_vel = snap_history[newest].vel;
         end else begin
            span = 64'(snap_history[hi_slot].time_us) - 64'(snap_history[lo_slot].time_us);
            prog = 64'(word.time_us) - 64'(snap_history[lo_slot].time_us);
            frac = (span != 0) ? (prog << FRAC_W) / span : 64'd0;
            if (frac > (64'd1 << FRAC_W))
               frac = 64'd1 << FRAC_W;
            ans.outcome = OUTCOME_INTERP;
            ans.shown_x = blend_coord(snap_history[lo_slot].pos.x,
                                      snap_history[hi_slot].pos.x, frac);
            ans.shown_y = blend_coord(snap_history[lo_slot].pos.y,
                                      snap_history[hi_slot].pos.y, frac);
            held_vel = snap_history[hi_slot].vel;
         end
      end
      ans.vel_x = held_vel.x;
      ans.vel_y = held_vel.y;
      query_answers.insert(query_answers.size(), ans);
   endtask

   task automatic check_field(input string name, input logic signed [POS_W-1:0] want,
                              input logic signed [POS_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // Compares one accepted result word with the oldest predicted answer.
   task automatic check_result();
      answer_type ans;
      if (query_answers.size() == 0) begin
         $error("result word with no query waiting: outcome %0d", rsp_tuser);
         errors++;
         return;
      end
      ans = query_answers[0];
      query_answers.delete(0);
      check_field("outcome", POS_W'(ans.outcome), POS_W'(rsp_tuser));
      check_field("shown_x", ans.shown_x, rsp_tdata[0*POS_W +: POS_W]);
      check_field("shown_y", ans.shown_y, rsp_tdata[1*POS_W +: POS_W]);
      check_field("held_vel_x", ans.vel_x, rsp_tdata[2*POS_W +: POS_W]);
      check_field("held_vel_y", ans.vel_y, rsp_tdata[3*POS_W +: POS_W]);
   endtask

   // Watch both channels at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         oldest_idx = 0;
         snap_fill = 0;
         held_vel = '0;
         query_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            track_request(req_tuser, req_tdata);
      end
      pending_count <= query_answers.size();
      mismatch_count <= errors;
   end

endmodule

@@ sim/testbench.sv @@
// Top of the interpolator testbench: clock, reset, stimulus, result flow control and verdict.
`timescale 1ns / 1ps

module testbench;
   import tsi_pkg::*;

   localparam int DEPTH = HISTORY_DEPTH_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // time_us, snap_pos_x, snap_pos_y, snap_vel_x, snap_vel_y
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   // req_type
   logic                  req_tuser = REQ_ADD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // shown_x, shown_y, held_vel_x, held_vel_y
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // outcome
   logic [1:0]            rsp_tuser;

   int mismatch_count;
   int pending_count;
   int send_idle_pct = 28;
   int recv_idle_pct = 82;
   int stall_request = 0;
   int hold_left = 0;

   timestamped_sample_interpolator #(.HISTORY_DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tsi_checker #(.HISTORY_DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reset held at start, then released.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop well past the slowest correct run.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Result side: random back-pressure, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (stall_request > 0) begin
         hold_left = stall_request;
         stall_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [SAMPLE_W-1:0] snap_word(input logic [31:0] t,
                                                     input logic [23:0] px, input logic [23:0] py,
                                                     input logic [23:0] vx, input logic [23:0] vy);
      return {vy, vx, py, px, t};
   endfunction

   // Coordinates lean toward the extremes now and then.
   function automatic logic [23:0] pick_coord();
      case ($urandom_range(9))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(3))
         0: return $urandom_range(1, 4);
         1: return $urandom_range(1, 1000);
         2: return $urandom_range(1, 1 << 20);
         default: return $urandom_range(1, 32'h0FFF_FFFF);
      endcase
   endfunction

   // Offers one word and waits until it is taken.
   task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic add_at(input logic [31:0] t);
      send_word(REQ_ADD, snap_word(t, pick_coord(), pick_coord(), pick_coord(), pick_coord()));
   endtask

   task automatic query_at(input logic [31:0] t);
      send_word(REQ_QUERY, snap_word(t, 24'($urandom), 24'($urandom), 24'($urandom),
                                     24'($urandom)));
   endtask

   // Stops offering words until every predicted answer has come back.
   // The count seen at an edge reflects the words taken up to the edge before.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Random traffic: mostly ordered bursts of snapshots followed by queries,
   // the rest lone words and bursts with repeated or shuffled timestamps.
   task automatic run_traffic(input int n_items);
      int          sent;
      int          pick;
      int          n_add;
      int          n_query;
      logic [31:0] t;
      logic [31:0] times [$];
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         times.delete();
         if (pick < 70) begin
            n_add = $urandom_range(1, DEPTH + 2);
            n_query = $urandom_range(1, 4);
            t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1000);
            for (int i = 0; i < n_add; i++) begin
               times.insert(times.size(), t);
               add_at(t);
               t = t + pick_step();
            end
            for (int j = 0; j < n_query; j++) begin
               case ($urandom_range(4))
                  0: query_at(times[$urandom_range(0, times.size() - 1)]);
                  1: query_at($urandom_range(times[0], times[$]));
                  2: query_at(times[0] - $urandom_range(1, 100));
                  3: query_at(times[$] + $urandom_range(0, 100));
                  default: query_at($urandom);
               endcase
            end
            sent += n_add + n_query;
         end else if (pick < 85) begin
            if ($urandom_range(1))
               add_at($urandom);
            else
               query_at($urandom);
            sent++;
         end else begin
            n_add = $urandom_range(1, 4);
            t = $urandom_range(0, 5000);
            for (int i = 0; i < n_add; i++) begin
               if ($urandom_range(1))
                  t = $urandom_range(0, 5000);
               add_at(t);
            end
            n_query = $urandom_range(1, 2);
            for (int j = 0; j < n_query; j++)
               query_at($urandom_range(0, 5000));
            sent += n_add + n_query;
         end
      end
   endtask

   // Main stimulus sequence and verdict.
   initial begin
      while (reset) @(posedge clock);

      // Empty history, then a single entry.
      query_at(32'd0);
      send_word(REQ_ADD, snap_word(32'd1000, 24'h7FFFFF, 24'h800000, 24'd100, -24'sd100));
      query_at(32'd500);
      query_at(32'd5000);

      // Two entries at opposite extremes: exact, near-end, middle and fallback queries.
      send_word(REQ_ADD, snap_word(32'd2000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
      query_at(32'd1000);
      query_at(32'd1999);
      query_at(32'd1500);
      query_at(32'd999);
      query_at(32'd2000);
      query_at(32'hFFFF_FFFF);

      // An out-of-order timestamp: skipped at 1700, returned as the newest entry at 2500.
      add_at(32'd1500);
      query_at(32'd1700);
      query_at(32'd2500);

      // Time extremes, then enough adds to wrap the full history.
      add_at(32'd0);
      add_at(32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++)
         add_at(32'd3000 + 32'd1000 * i);
      query_at(32'd0);
      query_at(32'd4500);
      query_at(32'hFFFF_FFFE);
      wait_drained();

      // Sender idles often less than the receiver.
      run_traffic(500);
      wait_drained();

      // Roles swapped.
      send_idle_pct = 82;
      recv_idle_pct = 28;
      run_traffic(500);
      wait_drained();

      // No idling, with one long hold-off on the result side in the middle.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_traffic(250);
      stall_request = 400;
      run_traffic(40);
      wait_drained();
      run_traffic(250);
      wait_drained();
      repeat (DEPTH + 30) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ timestamped_sample_interpolator.f @@
rtl/tsi_pkg.sv
rtl/tsi_ram.sv
rtl/tsi_frac_div.sv
rtl/tsi_blend.sv
rtl/timestamped_sample_interpolator.sv
sim/tsi_checker.sv
sim/testbench.sv
